@@ rtl/ipcs_pkg.sv @@
// Shared types, constants and the end-around-carry adder for the IPv4/TCP
// checksum engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipcs_pkg;

  // IP protocol number for TCP
  localparam logic [7:0]  IpprotoTcp = 8'd6;
  // smallest TCP header in bytes
  localparam logic [15:0] MinTcpHdr  = 16'd20;
  // even offsets of the source and destination address words
  localparam logic [15:0] AddrFirst  = 16'd12;
  localparam logic [15:0] AddrLast   = 16'd18;

  // Datagram totals handed from the accumulator to the finishing stages
  typedef struct packed {
    logic [15:0] hsum;
    logic [15:0] ssum;
    logic [15:0] count;
    logic [3:0]  hwords;
    logic [7:0]  proto;
    logic        ovf;
  } snap_t;

  // Ones'-complement add with end-around carry; one fold suffices for 16-bit inputs
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/ipv4_tcp_checksum_engine.sv @@
// Top level of the IPv4 header / TCP checksum engine: byte accumulator and
// datagram snapshot. Depends on ipcs_pkg and ipcs_finish.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Width          | Content
// s_*     | in        | tdata 8, tlast | datagram byte, last byte of datagram
// m_*     | out       | tdata 32, tuser 2 | both checksums, is_tcp and header_ok
//
// One byte is taken every cycle while m_* is not stalled; the result passes the
// snapshot, the length/flag stage and the result register after the last byte.
// The end-around-carry add into one of the two sums sets the byte rate.
// rst is synchronous and clears all sums, counts and valids.
// A result left untaken on m_* stalls the whole pipeline and drops s_tready.

module ipv4_tcp_checksum_engine #(
  parameter int MAX_DATAGRAM_BYTES = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] ip_header_checksum, [31:16] l4_checksum
  output logic [1:0]       m_tuser    // [0] is_tcp, [1] header_ok
);
  import ipcs_pkg::*;

  localparam logic [15:0] MaxBytes = 16'(MAX_DATAGRAM_BYTES);

  logic        adv;
  logic        accept;

  logic [15:0] byte_count;
  logic [3:0]  header_words;
  logic [7:0]  protocol_code;
  logic [15:0] header_sum;
  logic [15:0] segment_sum;
  logic [7:0]  pending_high_byte;
  logic        overflowed;

  logic        fin_valid;
  snap_t       fin_snap;

  logic        sat;
  logic        odd;
  logic        add_en;
  logic [15:0] word;
  logic [15:0] hp;
  logic [3:0]  hw_eff;
  logic        in_hdr;
  logic        in_addr;
  logic [15:0] seg_word;
  snap_t       snap_next;
  logic [7:0]  pending_next;

  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;

  // Pair bytes into big-endian words and pick the sums they join
  always_comb begin
    sat     = byte_count >= MaxBytes;
    odd     = byte_count[0];
    add_en  = sat ? (s_tlast && odd) : (odd || s_tlast);
    word    = (!sat && odd) ? {pending_high_byte, s_tdata} :
              (sat ? {pending_high_byte, 8'h00} : {s_tdata, 8'h00});
    hp      = {byte_count[15:1], 1'b0};
    hw_eff  = (!sat && byte_count == 16'd0) ? s_tdata[3:0] : header_words;
    in_hdr  = hp < {10'd0, hw_eff, 2'b00};
    in_addr = (hp >= AddrFirst) && (hp <= AddrLast);
    // an address word outside the header counts twice in the segment sum: double is a rotate
    seg_word = (!in_hdr && in_addr) ? {word[14:0], word[15]} : word;

    snap_next.hwords = hw_eff;
    snap_next.proto  = (!sat && byte_count == 16'd9) ? s_tdata : protocol_code;
    snap_next.count  = sat ? byte_count : byte_count + 16'd1;
    snap_next.ovf    = overflowed || sat;
    snap_next.hsum   = (add_en && in_hdr) ? oc_add(header_sum, word) : header_sum;
    snap_next.ssum   = (add_en && (!in_hdr || in_addr)) ?
                       oc_add(segment_sum, seg_word) : segment_sum;
    pending_next     = (!sat && !odd) ? s_tdata : pending_high_byte;
  end

  // Advance accumulator; on the last byte hand totals on and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= 16'd0;
      header_words      <= 4'd0;
      protocol_code     <= 8'd0;
      header_sum        <= 16'd0;
      segment_sum       <= 16'd0;
      pending_high_byte <= 8'd0;
      overflowed        <= 1'b0;
      fin_valid         <= 1'b0;
    end else begin
      if (adv) begin
        fin_valid <= accept && s_tlast;
      end
      if (accept) begin
        if (s_tlast) begin
          byte_count        <= 16'd0;
          header_words      <= 4'd0;
          protocol_code     <= 8'd0;
          header_sum        <= 16'd0;
          segment_sum       <= 16'd0;
          pending_high_byte <= 8'd0;
          overflowed        <= 1'b0;
        end else begin
          byte_count        <= snap_next.count;
          header_words      <= snap_next.hwords;
          protocol_code     <= snap_next.proto;
          header_sum        <= snap_next.hsum;
          segment_sum       <= snap_next.ssum;
          pending_high_byte <= pending_next;
          overflowed        <= snap_next.ovf;
        end
      end
    end
  end

  // Hold datagram totals for the finishing stages
  always_ff @(posedge clk) begin
    if (adv) begin
      fin_snap <= snap_next;
    end
  end

  ipcs_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (fin_valid),
    .snap       (fin_snap),
    .adv        (adv),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MaxBytes)
    else $error("byte count beyond the datagram limit");
  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> byte_count == MaxBytes)
    else $error("overflow flagged below the datagram limit");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> byte_count == 16'd0 && header_sum == 16'd0 &&
    segment_sum == 16'd0 && !overflowed)
    else $error("accumulator not cleared after the last word");
`endif

endmodule

`default_nettype wire

@@ rtl/ipcs_finish.sv @@
// Finishing stages: segment length, flags, pseudo-header fold and the
// result register. Depends on ipcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipcs_finish (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          snap_valid,
  input  wire ipcs_pkg::snap_t snap,
  output logic               adv,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [31:0]        m_tdata,   // [15:0] ip_header_checksum, [31:16] l4_checksum
  output logic [1:0]         m_tuser    // [0] is_tcp, [1] header_ok
);
  import ipcs_pkg::*;

  logic        mid_valid;
  logic [15:0] mid_hdr_ck;
  logic [15:0] mid_seg6;
  logic [15:0] mid_seglen;
  logic        mid_tcp;
  logic        mid_ok;

  logic [5:0]  hb;
  logic        have_hdr;
  logic [15:0] seglen;
  logic        tcp;
  logic        ok;
  logic [15:0] l4_sum;

  // Whole pipeline moves unless a result waits untaken
  assign adv = !m_tvalid || m_tready;

  // Length and flags from the datagram totals
  always_comb begin
    hb       = {snap.hwords, 2'b00};
    have_hdr = snap.count >= {10'd0, hb};
    seglen   = have_hdr ? (snap.count - {10'd0, hb}) : 16'd0;
    tcp      = snap.proto == IpprotoTcp;
    ok       = (snap.hwords >= 4'd5) && !snap.ovf && have_hdr &&
               (!tcp || (seglen >= MinTcpHdr));
  end

  // Fold in the segment length
  assign l4_sum = oc_add(mid_seg6, mid_seglen);

  // Hold middle stage and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else if (adv) begin
      mid_valid <= snap_valid;
      m_tvalid  <= mid_valid;
    end
    if (adv) begin
      mid_hdr_ck <= ~snap.hsum;
      mid_seg6   <= oc_add(snap.ssum, {8'd0, IpprotoTcp});
      mid_seglen <= seglen;
      mid_tcp    <= tcp;
      mid_ok     <= ok;
      m_tdata    <= {(mid_tcp ? ~l4_sum : 16'd0), mid_hdr_ck};
      m_tuser    <= {mid_ok, mid_tcp};
    end
  end

`ifndef SYNTH
  a_l4_zero_non_tcp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[31:16] == 16'd0)
    else $error("transport checksum not zero for a non-TCP datagram");
  a_mid_to_out: assert property (@(posedge clk) disable iff (rst)
    mid_valid && adv |=> m_tvalid)
    else $error("finished datagram lost between stages");
  a_snap_to_mid: assert property (@(posedge clk) disable iff (rst)
    snap_valid && adv |=> mid_valid)
    else $error("datagram totals lost at the middle stage");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for ipv4_tcp_checksum_engine: streams IPv4 datagrams
// byte by byte and checks both checksums and flags against a local predictor.
// Depends on ipcs_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;
  import ipcs_pkg::*;

  localparam int MaxDatagramBytes = 65535;
  localparam int CycleLimit       = 1000000;
  localparam int DrainCycles      = 8;

  // One checksum result as the engine reports it
  typedef struct {
    logic [15:0] hdr_csum;
    logic [15:0] seg_csum;
    logic        tcp;
    logic        hdr_ok;
  } csum_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  // predictor state of the engine
  logic [15:0] dg_count;
  logic [3:0]  dg_ihl;
  logic [7:0]  dg_proto;
  logic [15:0] dg_hdr_sum;
  logic [15:0] dg_seg_sum;
  logic [7:0]  dg_high;
  logic        dg_ovf;

  csum_result_t pending_csums[$];
  logic [7:0]   frame_q[$];
  int           err_count = 0;
  int           bytes_sent = 0;
  int           frames_sent = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           rx_hold = 0;
  int unsigned  cycle_count = 0;

  ipv4_tcp_checksum_engine #(
    .MAX_DATAGRAM_BYTES(MaxDatagramBytes)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),     // [7:0] data_byte
    .s_tlast(s_tlast),     // last_byte
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),     // [15:0] ip_header_checksum, [31:16] l4_checksum
    .m_tuser(m_tuser)      // [0] is_tcp, [1] header_ok
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each taken result word with the oldest prediction
  always @(negedge clk) begin : result_check
    csum_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_csums.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b", m_tdata, m_tuser);
        err_count++;
      end else begin
        want = pending_csums.pop_front();
        if (m_tdata[15:0] !== want.hdr_csum) begin
          $error("ip_header_checksum: expected %h, got %h", want.hdr_csum, m_tdata[15:0]);
          err_count++;
        end
        if (m_tdata[31:16] !== want.seg_csum) begin
          $error("l4_checksum: expected %h, got %h", want.seg_csum, m_tdata[31:16]);
          err_count++;
        end
        if (m_tuser[0] !== want.tcp) begin
          $error("is_tcp: expected %b, got %b", want.tcp, m_tuser[0]);
          err_count++;
        end
        if (m_tuser[1] !== want.hdr_ok) begin
          $error("header_ok: expected %b, got %b", want.hdr_ok, m_tuser[1]);
          err_count++;
        end
      end
    end
  end

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // Fold one big-endian word into the header or segment sum; address words
  // also go into the pseudo header
  function automatic void fold_word(input int pos, input logic [15:0] word);
    if (pos < int'(dg_ihl) * 4)
      dg_hdr_sum = ones_add(dg_hdr_sum, word);
    else
      dg_seg_sum = ones_add(dg_seg_sum, word);
    if (pos >= int'(AddrFirst) && pos <= int'(AddrLast))
      dg_seg_sum = ones_add(dg_seg_sum, word);
  endfunction

  function automatic void clear_datagram();
    dg_count   = '0;
    dg_ihl     = '0;
    dg_proto   = '0;
    dg_hdr_sum = '0;
    dg_seg_sum = '0;
    dg_high    = '0;
    dg_ovf     = 1'b0;
  endfunction

  // Advance the predictor by one byte; returns 1 with the result on the last byte
  function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                      output csum_result_t res);
    int hdr_bytes;
    int seg_len;
    logic [15:0] s;
    if (int'(dg_count) >= MaxDatagramBytes) begin
      dg_ovf = 1'b1;
    end else begin
      if (dg_count == 16'd0) dg_ihl = b[3:0];
      if (dg_count == 16'd9) dg_proto = b;
      if (dg_count[0]) fold_word(int'(dg_count) - 1, {dg_high, b});
      else dg_high = b;
      dg_count = dg_count + 16'd1;
    end
    if (!last) return 1'b0;
    // odd tail: pad with a zero low byte
    if (dg_count[0]) fold_word(int'(dg_count) - 1, {dg_high, 8'h00});
    hdr_bytes = int'(dg_ihl) * 4;
    seg_len = (int'(dg_count) >= hdr_bytes) ? int'(dg_count) - hdr_bytes : 0;
    res.tcp = (dg_proto == IpprotoTcp);
    res.hdr_ok = (dg_ihl >= 4'd5) && !dg_ovf && (int'(dg_count) >= hdr_bytes) &&
                 (!res.tcp || seg_len >= int'(MinTcpHdr));
    res.hdr_csum = ~dg_hdr_sum;
    res.seg_csum = 16'h0000;
    if (res.tcp) begin
      s = ones_add(dg_seg_sum, {8'h00, IpprotoTcp});
      s = ones_add(s, seg_len[15:0]);
      res.seg_csum = ~s;
    end
    clear_datagram();
    return 1'b1;
  endfunction

  // Offer one byte, idling first at random; returns at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    csum_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(negedge clk);
    while (s_tready !== 1'b1) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
    if (predict_byte(b, last, res)) begin
      pending_csums.push_back(res);
      frames_sent++;
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Build a datagram: first byte and protocol as given, other bytes constant or random
  task automatic build_frame(input int len, input logic [7:0] first,
                             input logic [7:0] proto, input int fill);
    logic [7:0] b;
    frame_q.delete();
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      if (i == 0) b = first;
      if (i == 9) b = proto;
      frame_q.push_back(b);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_csums.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One-byte datagrams at both byte extremes
  task automatic test_single_bytes();
    build_frame(1, 8'h00, 8'h00, 0);
    send_frame();
    build_frame(1, 8'hFF, 8'h00, 0);
    send_frame();
  endtask

  // IHL zero (offset 0 in the segment) and a datagram ending inside the addresses
  task automatic test_short_frames();
    build_frame(6, 8'h40, 8'h00, 8'hA5);
    send_frame();
    build_frame(24, 8'h40, IpprotoTcp, -1);
    send_frame();
    build_frame(15, 8'h45, IpprotoTcp, 8'hFF);
    send_frame();
  endtask

  // Minimal TCP, odd length with zero padding, longest header without TCP
  task automatic test_full_frames();
    build_frame(40, 8'h45, IpprotoTcp, 8'hFF);
    send_frame();
    build_frame(41, 8'h45, IpprotoTcp, 8'h00);
    send_frame();
    build_frame(61, 8'h4F, 8'd17, -1);
    send_frame();
  endtask

  // Long datagrams: largest header with random payload, then an
  // odd length of all-ones bytes so the sums wrap many times
  task automatic test_long_frames();
    build_frame(200, 8'h4F, IpprotoTcp, -1);
    send_frame();
    build_frame(201, 8'h45, IpprotoTcp, 8'hFF);
    send_frame();
  endtask

  // Mostly well-formed datagrams with random content, some noise and truncation
  task automatic random_frame();
    int kind;
    int ihl;
    int len;
    int hdr_bytes;
    int r;
    logic [7:0] proto;
    logic [7:0] first;
    kind = $urandom_range(99);
    if (kind < 12) ihl = $urandom_range(4);
    else if (kind < 70) ihl = 5;
    else ihl = $urandom_range(15, 5);
    proto = ($urandom_range(99) < 70) ? IpprotoTcp : 8'($urandom_range(255));
    first = {4'h4, 4'(ihl)};
    // noise: any first byte at all
    if (kind >= 92) first = 8'($urandom_range(255));
    hdr_bytes = int'(first[3:0]) * 4;
    r = $urandom_range(99);
    if (r < 20) len = $urandom_range(hdr_bytes + 19, 1);
    else if (r < 95) len = hdr_bytes + $urandom_range(36, 20);
    else len = hdr_bytes + $urandom_range(200, 37);
    build_frame(len, first, proto, -1);
    send_frame();
  endtask

  task automatic test_random_traffic();
    int idle_set[4];
    int stall_set[4];
    int start_bytes;
    int start_frames;
    idle_set  = '{0, 63, 0, 15};
    stall_set = '{0, 0, 63, 15};
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = idle_set[p];
      rx_stall_pct = stall_set[p];
      start_bytes  = bytes_sent;
      start_frames = frames_sent;
      while (bytes_sent - start_bytes < 250 || frames_sent - start_frames < 5)
        random_frame();
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  // Long receiver hold-off while tiny datagrams keep coming; the engine must stall
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_hold = 300;
    for (int i = 0; i < 40; i++) begin
      build_frame($urandom_range(3, 1), 8'($urandom_range(255)), 8'h00, -1);
      send_frame();
    end
    drain();
  endtask

  initial begin
    clear_datagram();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_bytes();
    test_short_frames();
    test_full_frames();
    drain();
    test_long_frames();
    drain();
    test_backpressure();
    test_random_traffic();
    drain();

    if (err_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ ipv4_tcp_checksum_engine.f @@
rtl/ipcs_pkg.sv
rtl/ipcs_finish.sv
rtl/ipv4_tcp_checksum_engine.sv
tb/testbench.sv
